// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DDE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define DDE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ddet_pkg.sv -----
`timescale 1ns / 1ps
package ddet_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int MAX_RES    = 16;
    localparam int VALUE_BITS = 16;
    localparam int AVAIL_BITS = 20;
    localparam int P_W        = $clog2(MAX_PROCS);
    localparam int R_W        = $clog2(MAX_RES);
    localparam int CNT_W      = 5;
    localparam int MEM_AW     = P_W + R_W;
    localparam int MEM_DEPTH  = MAX_PROCS * MAX_RES;

    localparam logic [AVAIL_BITS-1:0] AVAIL_MAX = {AVAIL_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_LD_AVAIL = 2'd0,
        OP_LD_ALLOC = 2'd1,
        OP_LD_CLAIM = 2'd2,
        OP_RUN      = 2'd3
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [3:0]      proc_index;
        logic [3:0]      res_index;
        logic [15:0]     value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] proc_id;
        logic       finished;
        logic       all_finished;
        logic       last;
    } t_out_item;

    // Datapath actions selected by one microcode word.
    typedef enum logic [3:0] {
        A_NONE,
        A_IDLE,
        A_INIT,
        A_RINIT,
        A_CMP,
        A_FIN,
        A_ADD,
        A_PINC,
        A_SWEEP,
        A_EMIT
    } t_act;

    // Jump conditions; the jump is taken when the condition holds.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NORUN,
        C_DONE,
        C_RMORE,
        C_NOFIT,
        C_PMORE,
        C_PROG,
        C_OUTBUSY
    } t_cond;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_PCHK,
        S_RD,
        S_CMP,
        S_DEC,
        S_ARD,
        S_ADD,
        S_PNEXT,
        S_SWEEP,
        S_WAIT,
        S_EMIT,
        S_END
    } t_step;

    localparam int STEP_W = $bits(t_step);

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_act act;
    } t_ctrl;

    typedef struct packed {
        logic run_req;
        logic done_p;
        logic rmore;
        logic nofit;
        logic pmore;
        logic prog;
        logic out_busy;
    } t_stat;

endpackage

// ----- hw/rtl/ddet_ram.sv -----
`timescale 1ns / 1ps
module ddet_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ddet_seq.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddet_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ddet_pkg::t_stat i_stat,
    output ddet_pkg::t_ctrl o_ctrl
);
    import ddet_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take;

    // Control store: one word per step.
    always_comb begin
        case (r_step)
            S_IDLE:  uw = '{act: A_IDLE,  cond: C_NORUN,   target: S_IDLE};
            S_INIT:  uw = '{act: A_INIT,  cond: C_NEVER,   target: S_IDLE};
            S_PCHK:  uw = '{act: A_RINIT, cond: C_DONE,    target: S_PNEXT};
            S_RD:    uw = '{act: A_NONE,  cond: C_NEVER,   target: S_IDLE};
            S_CMP:   uw = '{act: A_CMP,   cond: C_RMORE,   target: S_RD};
            S_DEC:   uw = '{act: A_FIN,   cond: C_NOFIT,   target: S_PNEXT};
            S_ARD:   uw = '{act: A_NONE,  cond: C_NEVER,   target: S_IDLE};
            S_ADD:   uw = '{act: A_ADD,   cond: C_RMORE,   target: S_ARD};
            S_PNEXT: uw = '{act: A_PINC,  cond: C_PMORE,   target: S_PCHK};
            S_SWEEP: uw = '{act: A_SWEEP, cond: C_PROG,    target: S_PCHK};
            S_WAIT:  uw = '{act: A_NONE,  cond: C_OUTBUSY, target: S_WAIT};
            S_EMIT:  uw = '{act: A_EMIT,  cond: C_PMORE,   target: S_WAIT};
            S_END:   uw = '{act: A_NONE,  cond: C_ALWAYS,  target: S_IDLE};
            default: uw = '{act: A_NONE,  cond: C_ALWAYS,  target: S_IDLE};
        endcase
    end

    always_comb begin
        case (uw.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_NORUN:   take = !i_stat.run_req;
            C_DONE:    take = i_stat.done_p;
            C_RMORE:   take = i_stat.rmore;
            C_NOFIT:   take = i_stat.nofit;
            C_PMORE:   take = i_stat.pmore;
            C_PROG:    take = i_stat.prog;
            C_OUTBUSY: take = i_stat.out_busy;
            default:   take = 1'b1;
        endcase
        n_step = take ? uw.target : t_step'(STEP_W'(r_step) + STEP_W'(1));
        o_ctrl.act = uw.act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    `DDE_ASSERT_NXT(a_run_starts, i_clk, i_rst_n, r_step == S_IDLE && i_stat.run_req, r_step == S_INIT, "run item did not start the program")
    `DDE_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, r_step == S_EMIT, !i_stat.out_busy, "result emitted into a stalled output register")

endmodule

// ----- hw/rtl/ddet_dpath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddet_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ddet_pkg::t_ctrl             i_ctrl,
    output ddet_pkg::t_stat             o_stat,
    input  logic [ddet_pkg::CNT_W-1:0]  i_proc_count,
    input  logic [ddet_pkg::CNT_W-1:0]  i_res_count,
    input  logic                        i_in_valid,
    input  ddet_pkg::t_in_item          i_in_item,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output ddet_pkg::t_out_item         o_out_item,
    input  logic                        i_out_stall
);
    import ddet_pkg::*;

    logic [AVAIL_BITS-1:0] r_avail [MAX_RES];
    logic [MAX_PROCS-1:0]  r_done;
    logic [CNT_W-1:0]      r_total;
    logic                  r_prog;
    logic                  r_fit;
    logic [P_W-1:0]        r_p;
    logic [R_W-1:0]        r_r;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [CNT_W-1:0]      np_eff;
    logic [CNT_W-1:0]      nr_eff;
    logic [P_W-1:0]        np_last;
    logic [R_W-1:0]        nr_last;
    logic                  accept;
    logic                  we_alloc;
    logic                  we_claim;
    logic [MEM_AW-1:0]     waddr;
    logic [MEM_AW-1:0]     raddr;
    logic [VALUE_BITS-1:0] alloc_q;
    logic [VALUE_BITS-1:0] claim_q;
    logic [AVAIL_BITS-1:0] avail_r;
    logic [AVAIL_BITS:0]   have;
    logic [AVAIL_BITS-1:0] avail_sum;
    logic                  short;

    // Counts of zero act as one, counts above the maximum as the maximum.
    always_comb begin
        np_eff = i_proc_count;
        if (np_eff == '0) begin
            np_eff = CNT_W'(1);
        end else if (np_eff > CNT_W'(MAX_PROCS)) begin
            np_eff = CNT_W'(MAX_PROCS);
        end
        nr_eff = i_res_count;
        if (nr_eff == '0) begin
            nr_eff = CNT_W'(1);
        end else if (nr_eff > CNT_W'(MAX_RES)) begin
            nr_eff = CNT_W'(MAX_RES);
        end
        np_last = P_W'(np_eff - CNT_W'(1));
        nr_last = R_W'(nr_eff - CNT_W'(1));
    end

    assign o_in_stall = (i_ctrl.act != A_IDLE);
    assign accept     = (i_ctrl.act == A_IDLE) && i_in_valid;
    assign we_alloc   = accept && (i_in_item.op == OP_LD_ALLOC);
    assign we_claim   = accept && (i_in_item.op == OP_LD_CLAIM);
    assign waddr      = {P_W'(i_in_item.proc_index), R_W'(i_in_item.res_index)};
    assign raddr      = {r_p, r_r};

    ddet_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEM_DEPTH)) u_alloc (
        .i_clk   (i_clk),
        .i_we    (we_alloc),
        .i_waddr (waddr),
        .i_wdata (i_in_item.value),
        .i_raddr (raddr),
        .o_rdata (alloc_q)
    );

    ddet_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEM_DEPTH)) u_claim (
        .i_clk   (i_clk),
        .i_we    (we_claim),
        .i_waddr (waddr),
        .i_wdata (i_in_item.value),
        .i_raddr (raddr),
        .o_rdata (claim_q)
    );

    // A process fits a resource when its claim is within available plus
    // what it already holds; the same sum, saturated, is the release value.
    always_comb begin
        avail_r   = r_avail[r_r];
        have      = {1'b0, avail_r} + (AVAIL_BITS + 1)'(alloc_q);
        short     = (AVAIL_BITS + 1)'(claim_q) > have;
        avail_sum = have[AVAIL_BITS] ? AVAIL_MAX : have[AVAIL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.op == OP_LD_AVAIL) begin
            r_avail[R_W'(i_in_item.res_index)] <= AVAIL_BITS'(i_in_item.value);
        end else if (i_ctrl.act == A_ADD) begin
            r_avail[r_r] <= avail_sum;
        end
        if (i_ctrl.act == A_EMIT) begin
            r_out_item.proc_id      <= 4'(r_p);
            r_out_item.finished     <= r_done[r_p];
            r_out_item.all_finished <= (r_total == np_eff);
            r_out_item.last         <= (r_p == np_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_total     <= '0;
            r_prog      <= 1'b0;
            r_fit       <= 1'b0;
            r_p         <= '0;
            r_r         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_ctrl.act)
                A_INIT: begin
                    r_done  <= '0;
                    r_total <= '0;
                    r_prog  <= 1'b0;
                    r_p     <= '0;
                end
                A_RINIT: begin
                    r_r   <= '0;
                    r_fit <= 1'b1;
                end
                A_CMP: begin
                    if (short) begin
                        r_fit <= 1'b0;
                    end
                    r_r <= r_r + R_W'(1);
                end
                A_FIN: begin
                    if (r_fit) begin
                        r_done[r_p] <= 1'b1;
                        r_total     <= r_total + CNT_W'(1);
                        r_prog      <= 1'b1;
                    end
                    r_r <= '0;
                end
                A_ADD: begin
                    r_r <= r_r + R_W'(1);
                end
                A_PINC: begin
                    r_p <= r_p + P_W'(1);
                end
                A_SWEEP: begin
                    r_prog <= 1'b0;
                    r_p    <= '0;
                end
                A_EMIT: begin
                    r_p <= r_p + P_W'(1);
                end
                default: begin
                end
            endcase
            if (i_ctrl.act == A_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.run_req  = i_in_valid && (i_in_item.op == OP_RUN);
        o_stat.done_p   = r_done[r_p];
        o_stat.rmore    = (r_r != nr_last);
        o_stat.nofit    = !r_fit;
        o_stat.pmore    = (r_p != np_last);
        o_stat.prog     = r_prog;
        o_stat.out_busy = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `DDE_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= CNT_W'(MAX_PROCS),
        "finished count exceeds the process limit")
    `DDE_ASSERT_IMP(a_all_means_fin, i_clk, i_rst_n,
        r_out_valid && r_out_item.all_finished, r_out_item.finished,
        "all finished flagged on a deadlocked process")

endmodule

// ----- hw/rtl/deadlock_detection_engine.sv -----
// Load items are accepted one per cycle while idle. A run first clears the finished flags; each
// sweep then skips processes in use that already finished, compares each other one's claims per
// resource, and adds back its allocations if all fit. Sweeps repeat while one made progress, then
// one result per process in use leaves as the output register frees; the input stalls until idle.
// Synchronous active-low reset clears control state and sets both counts to 16; the
// available vector and the matrices keep whatever they held.
`timescale 1ns / 1ps
module deadlock_detection_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ddet_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ddet_pkg::t_out_item  o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ddet_pkg::*;

    logic [CNT_W-1:0] r_proc_count;
    logic [CNT_W-1:0] r_res_count;
    logic             cfg_wr;
    t_ctrl            ctrl;
    t_stat            stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register one sits at byte address 4; the low address bits are the byte offset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= CNT_W'(MAX_PROCS);
            r_res_count  <= CNT_W'(MAX_RES);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_res_count <= pwdata[CNT_W-1:0];
            end else begin
                r_proc_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? 32'(r_res_count) : 32'(r_proc_count);

    ddet_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ddet_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_proc_count (r_proc_count),
        .i_res_count  (r_res_count),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ----- tb/deadlock_detection_engine_tb.sv -----
`timescale 1ns / 1ps
module deadlock_detection_engine_tb;
    import ddet_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int IDLE_PAUSE   = 8;
    localparam int END_DRAIN    = 64;
    localparam int ITEM_TARGET  = 100;
    localparam int FIXED_PHASES = 3;

    typedef enum logic [2:0] {
        REG_PROC_COUNT = 3'd0,
        REG_RES_COUNT  = 3'd4
    } reg_addr_e;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET,
        ROW_READ
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        reg_addr_e   addr;
        logic [4:0]  data;
        t_in_item    item;
        logic        typed;
        logic [15:0] fin_mask;
        logic        all_fin;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the block's matrices, vector and count registers.
    logic [AVAIL_BITS-1:0] avail_m [MAX_RES];
    logic [15:0]           alloc_m [MAX_PROCS][MAX_RES];
    logic [15:0]           claim_m [MAX_PROCS][MAX_RES];
    bit                    avail_set [MAX_RES];
    bit                    alloc_set [MAX_PROCS][MAX_RES];
    bit                    claim_set [MAX_PROCS][MAX_RES];
    logic [4:0]            proc_reg;
    logic [4:0]            res_reg;

    t_out_item want_q[$];
    int        err_cnt;
    int        items_sent;
    int        runs_done;
    int        stuck_runs;
    int        sat_hits;
    int        results_seen;
    bit        hold_req;
    bit        calm;

    // Directed rows; typed expectations are given only where they are obvious.
    dir_row_t dir_rows [26] = '{
        '{ROW_READ, REG_PROC_COUNT, 5'd16, '0, 1'b0, 16'h0, 1'b0},
        '{ROW_READ, REG_RES_COUNT, 5'd16, '0, 1'b0, 16'h0, 1'b0},
        '{ROW_SET, REG_PROC_COUNT, 5'd2, '0, 1'b0, 16'h0, 1'b0},
        '{ROW_SET, REG_RES_COUNT, 5'd2, '0, 1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_AVAIL, 4'd15, 4'd0, 16'd0},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_AVAIL, 4'd0, 4'd1, 16'hFFFF},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_ALLOC, 4'd0, 4'd0, 16'd5},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd0, 4'd0, 16'd3},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_ALLOC, 4'd0, 4'd1, 16'd0},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd0, 4'd1, 16'hFFFF},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_ALLOC, 4'd1, 4'd0, 16'd0},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd1, 4'd0, 16'd5},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_ALLOC, 4'd1, 4'd1, 16'hFFFF},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd1, 4'd1, 16'd0},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_RUN, 4'd0, 4'd0, 16'd0},
          1'b1, 16'h0003, 1'b1},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_RUN, 4'd9, 4'd6, 16'hA5A5},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd0, 4'd0, 16'hFFFF},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd1, 4'd0, 16'hFFFF},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_RUN, 4'd15, 4'd15, 16'hFFFF},
          1'b1, 16'h0000, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd0, 4'd0, 16'd20},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_CLAIM, 4'd1, 4'd0, 16'd10},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_LD_ALLOC, 4'd1, 4'd0, 16'd8},
          1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_RUN, 4'd3, 4'd12, 16'h5A5A},
          1'b0, 16'h0, 1'b0},
        '{ROW_SET, REG_PROC_COUNT, 5'd0, '0, 1'b0, 16'h0, 1'b0},
        '{ROW_SET, REG_RES_COUNT, 5'd0, '0, 1'b0, 16'h0, 1'b0},
        '{ROW_ITEM, REG_PROC_COUNT, 5'd0, '{OP_RUN, 4'd0, 4'd0, 16'd0},
          1'b0, 16'h0, 1'b0}
    };

    deadlock_detection_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int eff_count(input logic [4:0] v, input int top);
        if (v == 5'd0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_value(input bit big);
        if (big || $urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 9));
    endfunction

    function automatic logic [3:0] pick_index(input int n);
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, n - 1));
    endfunction

    // Updates the shadow state for one item; a run computes the safety sweep and,
    // when asked, queues one expected result per process in use.
    function automatic void apply_item(input t_in_item it, input bit keep);
        int                  np;
        int                  nr;
        int                  done_cnt;
        bit                  moved;
        bit                  fits;
        logic [15:0]         done_mask;
        logic [AVAIL_BITS:0] sum;
        t_out_item           res;
        case (it.op)
            OP_LD_AVAIL: begin
                avail_m[it.res_index] = AVAIL_BITS'(it.value);
                avail_set[it.res_index] = 1'b1;
            end
            OP_LD_ALLOC: begin
                alloc_m[it.proc_index][it.res_index] = it.value;
                alloc_set[it.proc_index][it.res_index] = 1'b1;
            end
            OP_LD_CLAIM: begin
                claim_m[it.proc_index][it.res_index] = it.value;
                claim_set[it.proc_index][it.res_index] = 1'b1;
            end
            OP_RUN: begin
                np = eff_count(proc_reg, MAX_PROCS);
                nr = eff_count(res_reg, MAX_RES);
                done_mask = '0;
                done_cnt = 0;
                do begin
                    moved = 1'b0;
                    for (int p = 0; p < np; p++) begin
                        fits = !done_mask[p];
                        for (int r = 0; r < nr; r++) begin
                            sum = {1'b0, avail_m[r]} + alloc_m[p][r];
                            if (claim_m[p][r] > sum)
                                fits = 1'b0;
                        end
                        if (fits) begin
                            moved = 1'b1;
                            done_mask[p] = 1'b1;
                            done_cnt++;
                            for (int r = 0; r < nr; r++) begin
                                sum = {1'b0, avail_m[r]} + alloc_m[p][r];
                                if (sum > AVAIL_MAX) begin
                                    avail_m[r] = AVAIL_MAX;
                                    sat_hits++;
                                end else begin
                                    avail_m[r] = sum[AVAIL_BITS-1:0];
                                end
                            end
                        end
                    end
                end while (moved);
                runs_done++;
                if (done_cnt != np)
                    stuck_runs++;
                if (keep) begin
                    for (int p = 0; p < np; p++) begin
                        res.proc_id      = 4'(p);
                        res.finished     = done_mask[p];
                        res.all_finished = (done_cnt == np);
                        res.last         = (p == np - 1);
                        want_q.push_back(res);
                    end
                end
            end
        endcase
    endfunction

    task automatic send_item(input t_in_item it, input bit typed,
                             input logic [15:0] mask, input logic all_fin);
        int gap;
        int np;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
        apply_item(it, !typed);
        if (typed && it.op == OP_RUN) begin
            np = eff_count(proc_reg, MAX_PROCS);
            for (int p = 0; p < np; p++)
                want_q.push_back('{4'(p), mask[p], all_fin, p == np - 1});
        end
    endtask

    task automatic reg_access(input reg_addr_e addr, input bit wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_check(input reg_addr_e addr, input logic [4:0] val);
        logic [31:0] rd;
        reg_access(addr, 1'b0, '0, rd);
        if (rd !== {27'b0, val}) begin
            $error("register 0x%0h: expected %0d, got %0d", addr, val, rd);
            err_cnt++;
        end
    endtask

    // Loads leave no result behind, so a short pause follows the last result.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic set_reg(input reg_addr_e addr, input logic [4:0] val);
        logic [31:0] rd;
        wait_idle();
        reg_access(addr, 1'b1, {27'b0, val}, rd);
        if (addr == REG_PROC_COUNT)
            proc_reg = val;
        else
            res_reg = val;
        read_check(addr, val);
    endtask

    initial begin : result_sink
        int        hold_left;
        int        pause_left;
        bit        held;
        bit        stall_next;
        t_out_item want;
        hold_left  = 0;
        pause_left = 0;
        held       = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (want_q.size() == 0) begin
                    $error("result for process %0d arrived with none pending",
                           o_out_item.proc_id);
                    err_cnt++;
                end else begin
                    want = want_q.pop_front();
                    results_seen++;
                    if (o_out_item.proc_id !== want.proc_id) begin
                        $error("proc_id: expected %0d, got %0d", want.proc_id,
                               o_out_item.proc_id);
                        err_cnt++;
                    end
                    if (o_out_item.finished !== want.finished) begin
                        $error("finished: expected %0d, got %0d", want.finished,
                               o_out_item.finished);
                        err_cnt++;
                    end
                    if (o_out_item.all_finished !== want.all_finished) begin
                        $error("all_finished: expected %0d, got %0d", want.all_finished,
                               o_out_item.all_finished);
                        err_cnt++;
                    end
                    if (o_out_item.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_out_item.last);
                        err_cnt++;
                    end
                end
            end
            // One long hold-off lets the block back up into its input side.
            if (hold_req && !held && o_out_valid) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (pause_left > 0) begin
                pause_left--;
                stall_next = 1'b1;
            end else begin
                pause_left = pick_gap();
                stall_next = (pause_left > 0);
                if (pause_left > 0)
                    pause_left--;
            end
            i_out_stall <= stall_next;
        end
    end

    initial begin : watchdog
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("FAIL deadlock_detection_engine");
        $finish;
    end

    initial begin : stimulus
        int         phase;
        int         rounds;
        int         nloads;
        int         nruns;
        int         np;
        int         nr;
        bit         big;
        logic [4:0] pc;
        logic [4:0] rc;
        t_in_item   it;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        proc_reg   = 5'd16;
        res_reg    = 5'd16;
        hold_req   = 1'b0;
        calm       = 1'b0;
        phase      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_READ: read_check(dir_rows[i].addr, dir_rows[i].data);
                ROW_SET:  set_reg(dir_rows[i].addr, dir_rows[i].data);
                default:  send_item(dir_rows[i].item, dir_rows[i].typed,
                                    dir_rows[i].fin_mask, dir_rows[i].all_fin);
            endcase
        end

        // Each phase picks the counts, loads every entry a run may read that is
        // still unwritten, then mixes fresh loads with back-to-back runs. The first
        // phase holds the receiver off; the next two push one count past its maximum.
        while (items_sent < ITEM_TARGET || phase < FIXED_PHASES) begin
            case (phase)
                0: begin
                    pc = 5'd2;
                    rc = 5'd2;
                end
                1: begin
                    pc = 5'd31;
                    rc = 5'd1;
                end
                2: begin
                    pc = 5'd1;
                    rc = 5'd31;
                end
                default: begin
                    pc = 5'($urandom_range(1, 4));
                    rc = 5'($urandom_range(1, 4));
                end
            endcase
            big = (phase == 1);
            set_reg(REG_PROC_COUNT, pc);
            set_reg(REG_RES_COUNT, rc);
            np = eff_count(pc, MAX_PROCS);
            nr = eff_count(rc, MAX_RES);
            calm = ($urandom_range(0, 3) == 0);

            for (int r = 0; r < nr; r++) begin
                if (!avail_set[r]) begin
                    it = '{OP_LD_AVAIL, 4'($urandom), 4'(r), pick_value(big)};
                    send_item(it, 1'b0, '0, 1'b0);
                end
            end
            for (int p = 0; p < np; p++) begin
                for (int r = 0; r < nr; r++) begin
                    if (!alloc_set[p][r]) begin
                        it = '{OP_LD_ALLOC, 4'(p), 4'(r), pick_value(big)};
                        send_item(it, 1'b0, '0, 1'b0);
                    end
                    if (!claim_set[p][r]) begin
                        // Small claims against large allocations make the vector
                        // grow run after run until it saturates.
                        it = '{OP_LD_CLAIM, 4'(p), 4'(r),
                               big ? 16'($urandom_range(0, 300)) : pick_value(1'b0)};
                        send_item(it, 1'b0, '0, 1'b0);
                    end
                end
            end

            rounds = $urandom_range(2, 4);
            for (int k = 0; k < rounds; k++) begin
                nloads = $urandom_range(0, 6);
                repeat (nloads) begin
                    it.op         = t_op'($urandom_range(0, 2));
                    it.proc_index = pick_index(np);
                    it.res_index  = pick_index(nr);
                    it.value      = pick_value(1'b0);
                    send_item(it, 1'b0, '0, 1'b0);
                end
                if (phase == 0 && k == 0) begin
                    nruns = 2;
                    hold_req = 1'b1;
                end else begin
                    nruns = $urandom_range(1, 2);
                end
                repeat (nruns) begin
                    it = '{OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom)};
                    send_item(it, 1'b0, '0, 1'b0);
                end
            end
            phase++;
        end

        wait_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        $display("Covered %0d items in %0d phases: %0d detection runs, %0d left processes stuck.",
                 items_sent, phase, runs_done, stuck_runs);
        $display("Checked %0d results; available vector saturated %0d times; %0d mismatches.",
                 results_seen, sat_hits, err_cnt);
        if (err_cnt == 0)
            $display("PASS deadlock_detection_engine");
        else
            $display("FAIL deadlock_detection_engine");
        $finish;
    end

endmodule
